// ----- rtl/text_console_cell_writer_unit_assert.svh -----
// Assertion macros used by the console cell writer top-level unit.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TCW_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define TCW_ASSERT(name, prop, msg)
`define TCW_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- rtl/tcw_pkg.sv -----
// Types and constants shared by the console cell writer modules.
`default_nettype none
package tcw_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Special characters and the blank cell value.
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_BACKSPACE = 8'd8;
    localparam logic [15:0] BLANK_CELL   = 16'h0020;

    localparam int unsigned COL_W = 7;
    localparam int unsigned ROW_W = 5;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       char_code;
        logic [3:0]       foreground;
        logic [3:0]       background;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } in_item_t;

    typedef struct packed {
        logic [15:0]      cell_word;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_line;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_END,
        ST_IDLE,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic walk;
        logic walk_clear;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scroll_req;
        logic clear_req;
        logic walk_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and a read port that returns the old data on a collision.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
// Controller state machine of the console cell writer.
`default_nettype none
module tcw_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tcw_pkg::status_t st,
    output tcw_pkg::cmd_t         cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    // State register; reset starts the clearing pass over the cell store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.exec       = 1'b0;
        cmd.walk       = 1'b0;
        cmd.walk_clear = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                cmd.walk       = 1'b1;
                cmd.walk_clear = 1'b1;
                if (st.walk_last) begin
                    state_next = tcw_pkg::ST_INIT_END;
                end
            end
            tcw_pkg::ST_INIT_END: begin
                // The last blank write of the pass lands in this cycle.
                state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.exec = 1'b1;
                    if (st.clear_req) begin
                        state_next = tcw_pkg::ST_CLEAR;
                    end else if (st.scroll_req) begin
                        state_next = tcw_pkg::ST_SCROLL;
                    end else begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                end
            end
            tcw_pkg::ST_SCROLL: begin
                cmd.walk = 1'b1;
                if (st.walk_last) begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_CLEAR: begin
                cmd.walk       = 1'b1;
                cmd.walk_clear = 1'b1;
                if (st.walk_last) begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_INIT;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
// Datapath of the console cell writer: cursor, cell store, walk engine, result register.
`default_nettype none
module tcw_datapath #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tcw_pkg::in_item_t s_data,
    input  wire tcw_pkg::cmd_t     cmd,
    output tcw_pkg::status_t       st,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tcw_pkg::out_item_t     m_data
);

    localparam int unsigned CELLS = COLUMNS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned CW    = tcw_pkg::COL_W;
    localparam int unsigned RW    = tcw_pkg::ROW_W;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_X    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_Y    = RW'(ROWS - 1);
    localparam logic [CW:0]   COL_LIMIT = (CW + 1)'(COLUMNS);
    localparam logic [RW:0]   ROW_LIMIT = (RW + 1)'(ROWS);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] y,
                                                input logic [CW-1:0] x);
        cell_addr = AW'(AW'(y) * COL_STEP + AW'(x));
    endfunction

    logic [CW-1:0]      cursor_x_reg, cursor_x_next;
    logic [RW-1:0]      cursor_y_reg, cursor_y_next;
    logic [AW-1:0]      walk_cnt_reg, walk_cnt_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               pend_blank_reg, pend_blank_next;
    logic               read_hit_reg, read_hit_next;
    logic               m_valid_reg, m_valid_next;
    tcw_pkg::out_item_t m_data_reg, m_data_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    // Item decode: cursor update, cell write and cell read for one accepted transfer.
    logic          ex_we, ex_re, ex_hit, ex_scroll, ex_clear;
    logic [AW-1:0] ex_waddr;
    logic [15:0]   ex_wdata;
    logic [CW-1:0] ex_x, bs_x;
    logic [RW-1:0] ex_y;
    logic          walk_copy;

    always_comb begin
        ex_x      = cursor_x_reg;
        ex_y      = cursor_y_reg;
        ex_we     = 1'b0;
        ex_waddr  = cell_addr(cursor_y_reg, cursor_x_reg);
        ex_wdata  = {s_data.background, s_data.foreground, s_data.char_code};
        ex_scroll = 1'b0;
        ex_clear  = 1'b0;
        ex_hit    = ({1'b0, s_data.column} < COL_LIMIT) && ({1'b0, s_data.row} < ROW_LIMIT);
        ex_re     = 1'b0;
        bs_x      = (cursor_x_reg != '0) ? cursor_x_reg - CW'(1) : cursor_x_reg;
        case (s_data.kind)
            tcw_pkg::KIND_PRINT: begin
                if (s_data.char_code == tcw_pkg::CH_NEWLINE) begin
                    ex_x = '0;
                    if (cursor_y_reg == LAST_Y) begin
                        ex_scroll = 1'b1;
                    end else begin
                        ex_y = cursor_y_reg + RW'(1);
                    end
                end else if (s_data.char_code == tcw_pkg::CH_BACKSPACE) begin
                    ex_x     = bs_x;
                    ex_we    = 1'b1;
                    ex_waddr = cell_addr(cursor_y_reg, bs_x);
                    ex_wdata = tcw_pkg::BLANK_CELL;
                end else begin
                    ex_we = 1'b1;
                    if (cursor_x_reg == LAST_X) begin
                        ex_x = '0;
                        if (cursor_y_reg == LAST_Y) begin
                            ex_scroll = 1'b1;
                        end else begin
                            ex_y = cursor_y_reg + RW'(1);
                        end
                    end else begin
                        ex_x = cursor_x_reg + CW'(1);
                    end
                end
            end
            tcw_pkg::KIND_SET: begin
                ex_x = ({1'b0, s_data.column} < COL_LIMIT) ? s_data.column : LAST_X;
                ex_y = ({1'b0, s_data.row} < ROW_LIMIT) ? s_data.row : LAST_Y;
            end
            tcw_pkg::KIND_CLEAR: begin
                ex_x     = '0;
                ex_y     = '0;
                ex_clear = 1'b1;
            end
            default: begin
                ex_re = ex_hit;
            end
        endcase
    end

    // Walk engine: scroll copies a cell one row up per cycle and blanks the last row, clear writes blanks.
    // Each write follows its read in the next cycle so the registered read data lines up.
    always_comb begin
        walk_copy       = !cmd.walk_clear && (walk_cnt_reg < COPY_END);
        walk_cnt_next   = '0;
        pend_next       = 1'b0;
        pend_addr_next  = walk_cnt_reg;
        pend_blank_next = !walk_copy;
        if (cmd.walk) begin
            pend_next     = 1'b1;
            walk_cnt_next = (walk_cnt_reg == LAST_CELL) ? '0 : walk_cnt_reg + AW'(1);
        end
    end

    // Memory port selection.
    always_comb begin
        if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_blank_reg ? tcw_pkg::BLANK_CELL : ram_rdata;
        end else begin
            ram_we    = cmd.exec && ex_we;
            ram_waddr = ex_waddr;
            ram_wdata = ex_wdata;
        end
        if (cmd.walk) begin
            ram_re    = walk_copy;
            ram_raddr = walk_cnt_reg + COL_STEP;
        end else begin
            ram_re    = cmd.exec && ex_re;
            ram_raddr = cell_addr(s_data.row, s_data.column);
        end
    end

    // Cursor, read flag and result register updates.
    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        read_hit_next = read_hit_reg;
        if (cmd.exec) begin
            cursor_x_next = ex_x;
            cursor_y_next = ex_y;
            read_hit_next = ex_re;
        end
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load_out) begin
            m_valid_next            = 1'b1;
            m_data_next.cell_word   = read_hit_reg ? ram_rdata : 16'h0000;
            m_data_next.cursor_col  = cursor_x_reg;
            m_data_next.cursor_line = cursor_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            walk_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            read_hit_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            walk_cnt_reg <= walk_cnt_next;
            pend_reg     <= pend_next;
            read_hit_reg <= read_hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        pend_blank_reg <= pend_blank_next;
        m_data_reg     <= m_data_next;
    end

    // Character-cell store.
    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Status to the controller.
    assign st.scroll_req = ex_scroll;
    assign st.clear_req  = ex_clear;
    assign st.walk_last  = (walk_cnt_reg == LAST_CELL);
    assign st.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/text_console_cell_writer_unit.sv -----
// Print and newline without scroll, backspace, set cursor and read cell are accepted in ST_IDLE,
// then ST_DONE loads the result register once it is free. Scroll and clear first pass through
// ST_SCROLL or ST_CLEAR, which sweep the cell store once, one cell per cycle. No new item is taken
// until the result register is loaded. Reset is synchronous and active low; it clears cursor and
// control state and then runs a clearing pass over the cell store with s_ready low.
// A finished result waits in the output register while the next transfer is accepted.
`default_nettype none
`include "text_console_cell_writer_unit_assert.svh"
module text_console_cell_writer_unit #(
    parameter int unsigned COLUMNS = 80,
    parameter int unsigned ROWS    = 25
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tcw_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tcw_pkg::out_item_t      m_data
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t st;

    // Sequencing of items and store sweeps.
    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Cursor, cell store and result register.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A clear transfer blocks the input while the store is swept.
    `TCW_ASSERT(a_clear_blocks, s_valid && s_ready && s_data.kind == tcw_pkg::KIND_CLEAR |=> !s_ready, "clear did not start a sweep")
    // A result is never loaded over one that has not been taken.
    `TCW_ASSERT(a_no_overwrite, cmd.load_out |-> st.out_free, "result register overwritten")
    // The reported cursor is always on the screen.
    `TCW_ASSERT(a_cursor_range, m_valid |-> m_data.cursor_col < COLUMNS && m_data.cursor_line < ROWS, "cursor off screen")
    // Reset empties the output and starts the clearing pass.
    `TCW_ASSERT_ALWAYS(a_reset_state, !aresetn |=> !m_valid && !s_ready, "reset state wrong")

endmodule
`default_nettype wire
